[rtl/tlsm_pkg.sv]
// Shared types and constants for the two-list sorted merge block.
`default_nettype none
package tlsm_pkg;

   // Fixed field widths of the request and response streams
   localparam int CMD_W      = 2;
   localparam int KEY_IN_W   = 32;
   localparam int TAG_W      = 8;
   localparam int REQ_DATA_W = KEY_IN_W + TAG_W;
   localparam int RSP_DATA_W = KEY_IN_W + TAG_W;

   // Request commands carried on req_tuser
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_MERGE  = 2'd2
   } cmd_type;

endpackage
`default_nettype wire

[rtl/two_list_sorted_merge.sv]
// Top level of the two-list sorted merge: list RAMs, load/merge control, response register.
//
//  channel | dir | tdata (low bit up)        | tuser            | tlast
//  req_    | in  | key[31:0], tag[39:32]     | cmd[1:0]         | -
//  rsp_    | out | out_key[31:0], tag[39:32] | empty_res        | last
//
// A merge first accepts the request and starts the first reads of both list
// RAMs, then emits one record per cycle while rsp_tready does not stall it
// (count_a + count_b records, or a single marker record when both lists are
// empty); the registered read of the list RAMs is hidden by reading the
// next entry of the chosen list while the current record is sent.
// Reset is synchronous and clears only counts, indexes and control; the RAMs
// are not cleared. A stalled rsp_tready holds the merge in place.
`default_nettype none
module two_list_sorted_merge #(
   parameter int LIST_DEPTH = 32,
   parameter int KEY_WIDTH  = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [tlsm_pkg::REQ_DATA_W-1:0]   req_tdata,  // key[31:0], tag[39:32]
   input  wire logic [tlsm_pkg::CMD_W-1:0]        req_tuser,  // cmd[1:0]
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [tlsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_key[31:0], out_tag[39:32]
   output logic                                   rsp_tlast,  // last
   output logic                                   rsp_tuser   // empty_res
);
   import tlsm_pkg::*;

   localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int ENTRY_W = KEY_WIDTH + TAG_W;

   typedef enum logic {
      ST_IDLE,
      ST_PICK
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]       cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]       xa_ff, xa_in;
   logic [CNT_W-1:0]       xb_ff, xb_in;
   logic                   out_v_ff, out_v_in;
   logic [KEY_IN_W-1:0]    out_key_ff, out_key_in;
   logic [TAG_W-1:0]       out_tag_ff, out_tag_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_empty_ff, out_empty_in;

   logic                   req_fire;
   cmd_type                cmd;
   logic                   out_free;
   logic                   we_a, we_b, re_a, re_b;
   logic [ADDR_W-1:0]      ra_a, ra_b;
   logic [ENTRY_W-1:0]     wr_entry;
   logic [ENTRY_W-1:0]     rd_a, rd_b;
   logic signed [KEY_WIDTH-1:0] key_a, key_b, key_sel;
   logic [CNT_W-1:0]       xa_nx, xb_nx;
   logic                   a_av, b_av, take_a;

   // List storage
   assign wr_entry = {req_tdata[KEY_IN_W +: TAG_W], req_tdata[KEY_WIDTH-1:0]};

   tlsm_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_a (
      .clock  (clock),
      .wr_en  (we_a),
      .wr_addr(cnt_a_ff[ADDR_W-1:0]),
      .wr_data(wr_entry),
      .rd_en  (re_a),
      .rd_addr(ra_a),
      .rd_data(rd_a)
   );

   tlsm_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_b (
      .clock  (clock),
      .wr_en  (we_b),
      .wr_addr(cnt_b_ff[ADDR_W-1:0]),
      .wr_data(wr_entry),
      .rd_en  (re_b),
      .rd_addr(ra_b),
      .rd_data(rd_b)
   );

   // Heads of both lists come straight from the RAM read registers
   assign key_a = rd_a[KEY_WIDTH-1:0];
   assign key_b = rd_b[KEY_WIDTH-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign out_free   = !out_v_ff || rsp_tready;

   // Merge choice: A on strictly smaller signed key or when B is exhausted, B wins ties
   assign a_av   = (xa_ff < cnt_a_ff);
   assign b_av   = (xb_ff < cnt_b_ff);
   assign take_a = a_av && (!b_av || (key_a < key_b));
   assign xa_nx  = take_a ? (xa_ff + CNT_W'(1)) : xa_ff;
   assign xb_nx  = take_a ? xb_ff : (xb_ff + CNT_W'(1));
   assign key_sel = take_a ? key_a : key_b;

   // Next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      xa_in        = xa_ff;
      xb_in        = xb_ff;
      out_v_in     = out_v_ff && !rsp_tready;
      out_key_in   = out_key_ff;
      out_tag_in   = out_tag_ff;
      out_last_in  = out_last_ff;
      out_empty_in = out_empty_ff;
      we_a         = 1'b0;
      we_b         = 1'b0;
      re_a         = 1'b0;
      re_b         = 1'b0;
      ra_a         = '0;
      ra_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_LOAD_A: begin
                     if (cnt_a_ff < CNT_W'(LIST_DEPTH)) begin
                        we_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_W'(1);
                     end
                  end
                  CMD_LOAD_B: begin
                     if (cnt_b_ff < CNT_W'(LIST_DEPTH)) begin
                        we_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_W'(1);
                     end
                  end
                  CMD_MERGE: begin
                     // prefetch both heads
                     xa_in    = '0;
                     xb_in    = '0;
                     re_a     = 1'b1;
                     re_b     = 1'b1;
                     state_in = ST_PICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PICK: begin
            if (out_free) begin
               out_v_in = 1'b1;
               if (cnt_a_ff == '0 && cnt_b_ff == '0) begin
                  // both lists empty: single marker record
                  out_key_in   = '0;
                  out_tag_in   = '0;
                  out_last_in  = 1'b1;
                  out_empty_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  out_key_in   = KEY_IN_W'(key_sel);
                  out_tag_in   = take_a ? rd_a[KEY_WIDTH +: TAG_W] : rd_b[KEY_WIDTH +: TAG_W];
                  out_empty_in = 1'b0;
                  out_last_in  = (xa_nx == cnt_a_ff) && (xb_nx == cnt_b_ff);
                  xa_in        = xa_nx;
                  xb_in        = xb_nx;
                  // fetch the next entry of the list just consumed
                  if (take_a) begin
                     re_a = (xa_nx < cnt_a_ff);
                     ra_a = xa_nx[ADDR_W-1:0];
                  end else begin
                     re_b = (xb_nx < cnt_b_ff);
                     ra_b = xb_nx[ADDR_W-1:0];
                  end
                  if (out_last_in) begin
                     cnt_a_in = '0;
                     cnt_b_in = '0;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         xa_ff    <= '0;
         xb_ff    <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         xa_ff    <= xa_in;
         xb_ff    <= xb_in;
         out_v_ff <= out_v_in;
      end
      out_key_ff   <= out_key_in;
      out_tag_ff   <= out_tag_in;
      out_last_ff  <= out_last_in;
      out_empty_ff <= out_empty_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_tag_ff, out_key_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_empty_ff;

endmodule
`default_nettype wire

[rtl/tlsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tlsm_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[rtl/tlsm_checker.sv]
// Port-level assertions for the two-list sorted merge, bound to the top level.
`default_nettype none
module tlsm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [tlsm_pkg::CMD_W-1:0]        req_tuser,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [tlsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                              rsp_tlast,
   input wire logic                              rsp_tuser
);
   import tlsm_pkg::*;

   // A stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // The empty marker is always flagged as the last record of its merge
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("empty marker without last");

   // The empty marker carries zero key and tag
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("empty marker with nonzero data");

   // A merge request blocks new requests while it runs
   a_merge_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_MERGE |=> !req_tready)
      else $error("request accepted right after merge");

endmodule

bind two_list_sorted_merge tlsm_checker u_tlsm_checker (.*);
`default_nettype wire
